// ===== rtl/esft_pkg.sv =====
// Shared constants and types of the event subscription fan-out table.
package esft_pkg;

  // Table geometry
  localparam int MaxSubs    = 32;  // table entries, 1..63
  localparam int EventKinds = 12;  // event kinds in use, 1..12
  localparam int ResultCap  = 32;  // deliveries per push at most

  // Field widths
  localparam int IdW   = 16;
  localparam int MaskW = 12;
  localparam int EvW   = 4;
  localparam int KindW = 2;
  localparam int StatW = 2;
  localparam int OccW  = 6;

  localparam int AddrW   = (MaxSubs > 1) ? $clog2(MaxSubs) : 1;
  localparam int CntW    = $clog2(MaxSubs + 1);
  localparam int ResCntW = $clog2(ResultCap);

  localparam logic [MaskW-1:0] KindMask = MaskW'((64'd1 << EventKinds) - 64'd1);

  typedef enum logic [KindW-1:0] {
    KindSub    = 2'd0,
    KindUnsub  = 2'd1,
    KindRemove = 2'd2,
    KindPush   = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    StatDone     = 2'd0,
    StatFull     = 2'd1,
    StatNotFound = 2'd2,
    StatIgnored  = 2'd3
  } status_e;

  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic [IdW-1:0]   client;
  } entry_t;

endpackage

// ===== rtl/esft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module esft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/event_subscription_fanout_table.sv =====
// Top level: subscriber table with subscribe, unsubscribe, remove and push fan-out.
//
// Channel  Dir  tdata (low bit up)                          tuser (low bit up)         tlast
// s_axis   in   client_id[15:0] event_bits[27:16]          kind[1:0]                  -
//               event_id[31:28]
// m_axis   out  deliver_client[15:0] entries_in_use[21:16]  deliver_valid[0]          last
//               zero[23:22]                                 status[2:1]
//
// One beat is taken in, then the table is scanned, one entry per cycle through the
//   single RAM read port unless a stalled m_axis holds a push; a search that misses
//   runs over every entry in use, a hit ends it, and a removal, or an unsubscribe
//   that clears every bit, then fetches the last entry to refill the freed slot.
// s_axis_tready_o is high only while the sequencer is idle.
// Reset clears occupancy and control; table contents stay undefined until written.
// A stalled m_axis holds the scan of a push until the next delivery beat is taken.
module event_subscription_fanout_table
  import esft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // client_id, event_bits, event_id
  input  logic [1:0]  s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // deliver_client, entries_in_use, zero pad
  output logic [2:0]  m_axis_tuser_o,   // deliver_valid, status
  output logic        m_axis_tlast_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StMove,
    StEmit
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;      // entry whose data sits on the RAM output
  logic [CntW-1:0]   cnt_q, cnt_d;      // entries in use
  logic [AddrW-1:0]  slot_q, slot_d;    // slot freed by a removal
  kind_e             kind_q, kind_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [MaskW-1:0]  bits_q, bits_d;    // already limited to valid kinds
  logic [EvW-1:0]    ev_q, ev_d;
  logic              pend_vld_q, pend_vld_d;  // a match held back until the next is known
  logic [IdW-1:0]    pend_id_q, pend_id_d;
  logic [ResCntW-1:0] nres_q, nres_d;   // deliveries already sent for this push
  status_e           res_stat_q, res_stat_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic              out_dv_q, out_dv_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic              out_last_q, out_last_d;
  status_e           out_stat_q, out_stat_d;
  logic [OccW-1:0]   out_occ_q, out_occ_d;

  // table RAM
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [IdW+MaskW-1:0] ram_rdata;
  entry_t            ent;

  logic              out_free;
  logic              idx_ok;
  logic [MaskW-1:0]  in_bits;
  logic [EvW-1:0]    in_ev;
  logic              in_ev_ok;
  logic [MaskW-1:0]  clr_mask;

  assign ent       = entry_t'(ram_rdata);
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign idx_ok    = idx_q < cnt_q;
  assign in_bits   = s_axis_tdata_i[27:16] & KindMask;
  assign in_ev     = s_axis_tdata_i[31:28];
  assign in_ev_ok  = (32'(in_ev) < EventKinds) && (32'(in_ev) < MaskW);
  assign clr_mask  = ent.mask & ~bits_q;
  assign ram_raddr = idx_d[AddrW-1:0];

  assign s_axis_tready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    kind_d     = kind_q;
    id_d       = id_q;
    bits_d     = bits_q;
    ev_d       = ev_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    nres_d     = nres_q;
    res_stat_d = res_stat_q;
    out_vld_d  = out_vld_q;
    out_dv_d   = out_dv_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    out_stat_d = out_stat_q;
    out_occ_d  = out_occ_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          kind_d     = kind_e'(s_axis_tuser_i);
          id_d       = s_axis_tdata_i[15:0];
          bits_d     = in_bits;
          ev_d       = in_ev;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          nres_d     = '0;
          res_stat_d = StatDone;
          state_d    = StScan;
          if (kind_e'(s_axis_tuser_i) == KindSub && in_bits == '0) begin
            res_stat_d = StatIgnored;
            state_d    = StEmit;
          end
          if (kind_e'(s_axis_tuser_i) == KindPush && !in_ev_ok) begin
            res_stat_d = StatIgnored;
            state_d    = StEmit;
          end
        end
      end

      StScan: begin
        if (kind_q == KindPush) begin
          if ((pend_vld_q && nres_q == ResCntW'(ResultCap - 1)) || !idx_ok) begin
            // end of scan or result cap reached
            if (pend_vld_q) begin
              if (out_free) begin
                out_vld_d  = 1'b1;
                out_dv_d   = 1'b1;
                out_id_d   = pend_id_q;
                out_last_d = 1'b1;
                out_stat_d = StatDone;
                out_occ_d  = OccW'(cnt_q);
                pend_vld_d = 1'b0;
                state_d    = StIdle;
              end
            end else begin
              res_stat_d = StatDone;
              state_d    = StEmit;
            end
          end else if (ent.mask[ev_q]) begin
            if (!pend_vld_q) begin
              pend_vld_d = 1'b1;
              pend_id_d  = ent.client;
              idx_d      = idx_q + CntW'(1);
            end else if (out_free) begin
              out_vld_d  = 1'b1;
              out_dv_d   = 1'b1;
              out_id_d   = pend_id_q;
              out_last_d = 1'b0;
              out_stat_d = StatDone;
              out_occ_d  = OccW'(cnt_q);
              nres_d     = nres_q + ResCntW'(1);
              pend_id_d  = ent.client;
              idx_d      = idx_q + CntW'(1);
            end
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end else begin
          if (!idx_ok) begin
            // client absent
            state_d = StEmit;
            if (kind_q == KindSub) begin
              if (cnt_q < CntW'(MaxSubs)) begin
                ram_we           = 1'b1;
                ram_waddr        = cnt_q[AddrW-1:0];
                ram_wdata.mask   = bits_q;
                ram_wdata.client = id_q;
                cnt_d            = cnt_q + CntW'(1);
                res_stat_d       = StatDone;
              end else begin
                res_stat_d = StatFull;
              end
            end else begin
              res_stat_d = StatNotFound;
            end
          end else if (ent.client == id_q) begin
            res_stat_d = StatDone;
            if (kind_q == KindSub) begin
              ram_we           = 1'b1;
              ram_waddr        = idx_q[AddrW-1:0];
              ram_wdata.mask   = ent.mask | bits_q;
              ram_wdata.client = id_q;
              state_d          = StEmit;
            end else if (kind_q == KindRemove || clr_mask == '0) begin
              // drop: fetch the last entry to refill this slot
              cnt_d   = cnt_q - CntW'(1);
              slot_d  = idx_q[AddrW-1:0];
              idx_d   = cnt_q - CntW'(1);
              state_d = StMove;
            end else begin
              ram_we           = 1'b1;
              ram_waddr        = idx_q[AddrW-1:0];
              ram_wdata.mask   = clr_mask;
              ram_wdata.client = id_q;
              state_d          = StEmit;
            end
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end

      StMove: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = ent;
        state_d   = StEmit;
      end

      StEmit: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_dv_d   = 1'b0;
          out_id_d   = '0;
          out_last_d = 1'b1;
          out_stat_d = res_stat_q;
          out_occ_d  = OccW'(cnt_q);
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= '0;
      cnt_q      <= '0;
      slot_q     <= '0;
      kind_q     <= KindSub;
      id_q       <= '0;
      bits_q     <= '0;
      ev_q       <= '0;
      pend_vld_q <= 1'b0;
      pend_id_q  <= '0;
      nres_q     <= '0;
      res_stat_q <= StatDone;
      out_vld_q  <= 1'b0;
      out_dv_q   <= 1'b0;
      out_id_q   <= '0;
      out_last_q <= 1'b0;
      out_stat_q <= StatDone;
      out_occ_q  <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      slot_q     <= slot_d;
      kind_q     <= kind_d;
      id_q       <= id_d;
      bits_q     <= bits_d;
      ev_q       <= ev_d;
      pend_vld_q <= pend_vld_d;
      pend_id_q  <= pend_id_d;
      nres_q     <= nres_d;
      res_stat_q <= res_stat_d;
      out_vld_q  <= out_vld_d;
      out_dv_q   <= out_dv_d;
      out_id_q   <= out_id_d;
      out_last_q <= out_last_d;
      out_stat_q <= out_stat_d;
      out_occ_q  <= out_occ_d;
    end
  end

  esft_ram #(
    .Width (IdW + MaskW),
    .Depth (MaxSubs)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_occ_q, out_id_q};
  assign m_axis_tuser_o  = {out_stat_q, out_dv_q};
  assign m_axis_tlast_o  = out_last_q;

  // occupancy never passes the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSubs))
    else $error("occupancy above table size");

  // occupancy moves by one entry at most per step
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CntW'(1) || cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("occupancy jumped");

  // an accepted beat starts a sequence; no second beat right behind it
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second beat taken while busy");

  // a held-back match never survives the end of a push
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_vld_q)
    else $error("pending delivery lost");

  // every non-delivery beat closes its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> m_axis_tlast_o)
    else $error("status beat without last");

endmodule

// ===== tb/event_subscription_fanout_table_tb.sv =====
// Self-checking testbench of the event subscription fan-out table.
`timescale 1ns / 100ps

module event_subscription_fanout_table_tb;
  import esft_pkg::*;

  localparam int PoolSize = 48;  // well-known client ids, more than the table holds

  // One m_axis beat as seen from outside
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   client;
    logic             last;
    status_e          status;
    logic [OccW-1:0]  occ;
  } beat_t;

  // One row of the directed stimulus; typed rows carry their own expected beat
  typedef struct packed {
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic [MaskW-1:0] bits;
    logic [EvW-1:0]   ev;
    logic             typed;
    status_e          status;
    logic [OccW-1:0]  occ;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // client_id, event_bits, event_id
  logic [1:0]  s_axis_tuser_i = '0;   // kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [23:0] m_axis_tdata_o;        // deliver_client, entries_in_use, zero pad
  logic [2:0]  m_axis_tuser_o;        // deliver_valid, status
  logic        m_axis_tlast_o;

  event_subscription_fanout_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the subscriber table
  logic [IdW-1:0]   shadow_client [MaxSubs];
  logic [MaskW-1:0] shadow_mask   [MaxSubs];
  int               shadow_count;

  beat_t due_results [$];

  int err_cnt;
  int sent_beats, seen_beats, deliveries, full_hits, dir_count;
  int send_idle_pct, recv_stall_pct;

  row_t dir_rows [24];

  function automatic logic [IdW-1:0] pool_id(input int idx);
    return IdW'(idx * 16'h0531) ^ 16'hA5C3;
  endfunction

  function automatic int find_slot(input logic [IdW-1:0] id);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_client[i] == id) return i;
    return -1;
  endfunction

  // Applies one command to the shadow table; with keep set, queues the beats it causes
  task automatic apply_table_op(input kind_e k, input logic [IdW-1:0] id,
                                input logic [MaskW-1:0] bits_in,
                                input logic [EvW-1:0] ev, input bit keep);
    logic [MaskW-1:0] bits;
    int               slot;
    int               total;
    int               n;
    status_e          st;
    bits = bits_in & KindMask;
    st = StatDone;
    n = 0;
    case (k)
      KindSub: begin
        if (bits == '0) begin
          st = StatIgnored;
        end else begin
          slot = find_slot(id);
          if (slot >= 0) begin
            shadow_mask[slot] = shadow_mask[slot] | bits;
          end else if (shadow_count < MaxSubs) begin
            shadow_client[shadow_count] = id;
            shadow_mask[shadow_count] = bits;
            shadow_count++;
          end else begin
            st = StatFull;
            full_hits++;
          end
        end
      end
      KindUnsub, KindRemove: begin
        slot = find_slot(id);
        if (slot < 0) begin
          st = StatNotFound;
        end else begin
          if (k == KindUnsub) shadow_mask[slot] = shadow_mask[slot] & ~bits;
          if (k == KindRemove || shadow_mask[slot] == '0) begin
            // last entry moves into the freed slot
            shadow_count--;
            shadow_client[slot] = shadow_client[shadow_count];
            shadow_mask[slot] = shadow_mask[shadow_count];
          end
        end
      end
      default: begin
        if (int'(ev) >= EventKinds || int'(ev) >= MaskW) begin
          st = StatIgnored;
        end else begin
          total = 0;
          for (int i = 0; i < shadow_count; i++)
            if (shadow_mask[i][ev] && total < ResultCap) total++;
          for (int i = 0; i < shadow_count && n < total; i++) begin
            if (shadow_mask[i][ev]) begin
              n++;
              deliveries++;
              if (keep) due_results.push_back('{1'b1, shadow_client[i], n == total,
                                                 StatDone, OccW'(shadow_count)});
            end
          end
        end
      end
    endcase
    if (n == 0 && keep) due_results.push_back('{1'b0, '0, 1'b1, st, OccW'(shadow_count)});
  endtask

  // Drives one s_axis beat at the falling edge and returns once it has been taken
  task automatic send_beat(input kind_e k, input logic [IdW-1:0] id,
                           input logic [MaskW-1:0] bits, input logic [EvW-1:0] ev,
                           input bit typed, input status_e st, input logic [OccW-1:0] occ);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ev, bits, id};
    s_axis_tuser_i  <= k;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_beats++;
    if (typed) begin
      apply_table_op(k, id, bits, ev, 1'b0);
      due_results.push_back('{1'b0, '0, 1'b1, st, occ});
    end else begin
      apply_table_op(k, id, bits, ev, 1'b1);
    end
  endtask

  task automatic send_cmd(input kind_e k, input logic [IdW-1:0] id,
                          input logic [MaskW-1:0] bits, input logic [EvW-1:0] ev);
    send_beat(k, id, bits, ev, 1'b0, StatDone, '0);
  endtask

  // Sender goes idle, then waits for every expected beat
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Random command, mostly on ids in the table or in the pool of well-known ids
  task automatic random_cmd();
    int               r;
    kind_e            k;
    logic [IdW-1:0]   id;
    logic [MaskW-1:0] bits;
    logic [EvW-1:0]   ev;
    r = $urandom_range(99);
    if (r < 35) k = KindSub;
    else if (r < 60) k = KindUnsub;
    else if (r < 75) k = KindRemove;
    else k = KindPush;
    r = $urandom_range(99);
    if (r < 50 && shadow_count > 0) id = shadow_client[$urandom_range(shadow_count - 1)];
    else if (r < 90) id = pool_id($urandom_range(PoolSize - 1));
    else id = IdW'($urandom);
    r = $urandom_range(99);
    if (r < 12) bits = '0;
    else if (r < 55) bits = MaskW'(1) << $urandom_range(MaskW - 1);
    else bits = MaskW'($urandom);
    if ($urandom_range(99) < 85) ev = EvW'($urandom_range(EventKinds - 1));
    else ev = EvW'($urandom_range(15));
    send_cmd(k, id, bits, ev);
  endtask

  // Fills the table with clients subscribed to one event, overflows it, then pushes that event
  task automatic fill_and_fanout();
    int             start;
    int             fill_ev;
    int             i;
    logic [IdW-1:0] id;
    fill_ev = $urandom_range(EventKinds - 1);
    start = $urandom_range(PoolSize - 1);
    for (i = 0; i < PoolSize && shadow_count < MaxSubs; i++)
      send_cmd(KindSub, pool_id((start + i) % PoolSize),
               MaskW'($urandom) | (MaskW'(1) << fill_ev), EvW'($urandom));
    i = 0;
    while (find_slot(pool_id(i)) >= 0) i++;
    id = pool_id(i);
    send_cmd(KindSub, id, MaskW'(1) << fill_ev, EvW'($urandom));
    send_cmd(KindPush, IdW'($urandom), MaskW'($urandom), EvW'(fill_ev));
  endtask

  // Result checker: every taken m_axis beat against the oldest expectation
  always @(posedge clk_i) begin
    beat_t want;
    beat_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_beats++;
      got = '{m_axis_tuser_o[0], m_axis_tdata_o[15:0], m_axis_tlast_o,
              status_e'(m_axis_tuser_o[2:1]), m_axis_tdata_o[21:16]};
      if (due_results.size() == 0) begin
        $error("unexpected result beat: client %h status %0d", got.client, got.status);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (got.valid !== want.valid) begin
          $error("deliver_valid: expected %0d, got %0d", want.valid, got.valid);
          err_cnt++;
        end
        if (got.client !== want.client) begin
          $error("deliver_client: expected %h, got %h", want.client, got.client);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.occ !== want.occ) begin
          $error("entries_in_use: expected %0d, got %0d", want.occ, got.occ);
          err_cnt++;
        end
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #4_000_000;
    $display("event_subscription_fanout_table_tb failed");
    $finish;
  end

  initial begin
    err_cnt = 0;
    sent_beats = 0;
    seen_beats = 0;
    deliveries = 0;
    full_hits = 0;
    shadow_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // kind, id, bits, ev, typed, status, occupancy
    dir_rows[0]  = '{KindPush,   16'h0000, 12'h000, 4'd0,  1'b1, StatDone,     6'd0};
    dir_rows[1]  = '{KindUnsub,  16'h1234, 12'hFFF, 4'd0,  1'b1, StatNotFound, 6'd0};
    dir_rows[2]  = '{KindRemove, 16'hFFFF, 12'h000, 4'd15, 1'b1, StatNotFound, 6'd0};
    dir_rows[3]  = '{KindSub,    16'h0000, 12'h000, 4'd0,  1'b1, StatIgnored,  6'd0};
    dir_rows[4]  = '{KindSub,    16'h0000, 12'hFFF, 4'd0,  1'b1, StatDone,     6'd1};
    dir_rows[5]  = '{KindSub,    16'hFFFF, 12'h001, 4'd15, 1'b1, StatDone,     6'd2};
    dir_rows[6]  = '{KindSub,    16'hFFFF, 12'h800, 4'd0,  1'b1, StatDone,     6'd2};
    dir_rows[7]  = '{KindPush,   16'h0000, 12'h000, 4'd0,  1'b0, StatDone,     6'd0};
    dir_rows[8]  = '{KindPush,   16'hFFFF, 12'hFFF, 4'd11, 1'b0, StatDone,     6'd0};
    dir_rows[9]  = '{KindPush,   16'h0000, 12'h000, 4'd5,  1'b0, StatDone,     6'd0};
    dir_rows[10] = '{KindPush,   16'h0000, 12'h000, 4'd12, 1'b1, StatIgnored,  6'd2};
    dir_rows[11] = '{KindPush,   16'hFFFF, 12'hFFF, 4'd15, 1'b1, StatIgnored,  6'd2};
    dir_rows[12] = '{KindUnsub,  16'hFFFF, 12'h000, 4'd0,  1'b1, StatDone,     6'd2};
    dir_rows[13] = '{KindUnsub,  16'h0000, 12'h0F0, 4'd0,  1'b1, StatDone,     6'd2};
    dir_rows[14] = '{KindPush,   16'h0000, 12'h000, 4'd4,  1'b0, StatDone,     6'd0};
    dir_rows[15] = '{KindUnsub,  16'hFFFF, 12'h801, 4'd0,  1'b1, StatDone,     6'd1};
    dir_rows[16] = '{KindSub,    16'hABCD, 12'h555, 4'd0,  1'b1, StatDone,     6'd2};
    dir_rows[17] = '{KindSub,    16'h5432, 12'hAAA, 4'd0,  1'b1, StatDone,     6'd3};
    dir_rows[18] = '{KindRemove, 16'h0000, 12'h000, 4'd0,  1'b1, StatDone,     6'd2};
    dir_rows[19] = '{KindPush,   16'h0000, 12'h000, 4'd1,  1'b0, StatDone,     6'd0};
    dir_rows[20] = '{KindPush,   16'h0000, 12'h000, 4'd0,  1'b0, StatDone,     6'd0};
    dir_rows[21] = '{KindUnsub,  16'hABCD, 12'hFFF, 4'd0,  1'b1, StatDone,     6'd1};
    dir_rows[22] = '{KindRemove, 16'h5432, 12'h000, 4'd0,  1'b1, StatDone,     6'd0};
    dir_rows[23] = '{KindPush,   16'h0000, 12'h000, 4'd2,  1'b1, StatDone,     6'd0};

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].bits, dir_rows[i].ev,
                dir_rows[i].typed, dir_rows[i].status, dir_rows[i].occ);
    dir_count = sent_beats;
    drain_results();

    // Idling phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (ph == 1 || ph == 2) begin
        fill_and_fanout();
        // sender holds off until every fan-out beat is out
        drain_results();
      end
      repeat (20) random_cmd();
      drain_results();
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    drain_results();
    repeat (80) @(posedge clk_i);

    $display("Ran %0d command beats (%0d directed), checked %0d result beats,",
             sent_beats, dir_count, seen_beats);
    $display("  %0d deliveries, %0d subscribes refused on a full table", deliveries, full_hits);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("event_subscription_fanout_table_tb passed");
    end else begin
      $display("event_subscription_fanout_table_tb failed");
    end
    $finish;
  end

endmodule
